/* design/shp_pkg.sv */
// shared types and constants for the 3x3 rgb sharpening stream
// used by shp_line_buf, shp_filter and sharpen_3x3_rgb_stream; no dependencies
`timescale 1ns / 1ps

package shp_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MIN_SIZE     = 3;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       drain;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // one column of the two stored lines
  typedef struct packed {
    rgb_t above;
    rgb_t current;
  } line_word_t;

  // control of one item as it leaves the input stage
  typedef struct packed {
    logic valid;      // item shifts the window
    logic pixel;      // real pixel enters the bottom row
    logic zero_col;   // drain past the last column: shift in zeros
    logic emit;       // item produces a result
    logic pass;       // border pixel, centre goes out unchanged
    logic frame_end;
  } stage_ctl_t;

endpackage

/* design/shp_line_buf.sv */
// two-line pixel store, one write port and one registered read port
// depends on shp_pkg for the line word type and depth
`timescale 1ns / 1ps

module shp_line_buf (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [shp_pkg::COL_W-1:0] rd_addr,
  output shp_pkg::line_word_t     rd_data,
  input  logic                    wr_en,
  input  logic [shp_pkg::COL_W-1:0] wr_addr,
  input  shp_pkg::line_word_t     wr_data
);
  import shp_pkg::*;

  line_word_t mem [MAX_WIDTH];
  line_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/shp_filter.sv */
// 3x3 window, sharpening arithmetic and result register
// depends on shp_pkg for pixel and control types
`timescale 1ns / 1ps

module shp_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  shp_pkg::stage_ctl_t  s1_ctl,
  input  shp_pkg::rgb_t        s1_px,
  input  shp_pkg::line_word_t  rd_data,
  output logic                 out_valid,
  output shp_pkg::pixel_out_t  out_data
);
  import shp_pkg::*;

  rgb_t       win_r [3][3];
  rgb_t       col_in [3];
  logic       emit_r;
  logic       pass_r;
  logic       end_r;
  logic       out_valid_r;
  pixel_out_t out_data_r;
  pixel_out_t out_data_nxt;

  // floor((11*c - 2*(n0+n1+n2+n3))/3) clamped to 0..255
  function automatic logic [7:0] sharpen(input logic [7:0] c, input logic [7:0] n0,
                                         input logic [7:0] n1, input logic [7:0] n2,
                                         input logic [7:0] n3);
    logic [11:0] c11;
    logic [11:0] s2;
    logic [11:0] diff;
    logic [19:0] prod;
    logic [7:0]  q;
    c11  = {1'b0, c, 3'b0} + {3'b0, c, 1'b0} + {4'b0, c};
    s2   = {1'b0, ({2'b0, n0} + {2'b0, n1} + {2'b0, n2} + {2'b0, n3}), 1'b0};
    diff = c11 - s2;
    // 683/2048 is exact for floor(x/3) while x stays below 768
    prod = {10'b0, diff[9:0]} * 20'd683;
    if (c11 < s2) begin
      q = 8'd0;
    end else if (diff >= 12'd768) begin
      q = 8'd255;
    end else begin
      q = prod[18:11];
    end
    return q;
  endfunction

  always_comb begin
    col_in[0] = s1_ctl.zero_col ? '0 : rd_data.above;
    col_in[1] = s1_ctl.zero_col ? '0 : rd_data.current;
    col_in[2] = s1_ctl.pixel ? s1_px : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (adv && s1_ctl.valid) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
        win_r[i][2] <= col_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
    end else if (adv) begin
      emit_r <= s1_ctl.valid && s1_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pass_r <= s1_ctl.pass;
      end_r  <= s1_ctl.frame_end;
    end
  end

  always_comb begin
    out_data_nxt.frame_end = end_r;
    if (pass_r) begin
      out_data_nxt.red_out   = win_r[1][1].r;
      out_data_nxt.green_out = win_r[1][1].g;
      out_data_nxt.blue_out  = win_r[1][1].b;
    end else begin
      out_data_nxt.red_out   = sharpen(win_r[1][1].r, win_r[0][1].r, win_r[2][1].r,
                                       win_r[1][0].r, win_r[1][2].r);
      out_data_nxt.green_out = sharpen(win_r[1][1].g, win_r[0][1].g, win_r[2][1].g,
                                       win_r[1][0].g, win_r[1][2].g);
      out_data_nxt.blue_out  = sharpen(win_r[1][1].b, win_r[0][1].b, win_r[2][1].b,
                                       win_r[1][0].b, win_r[1][2].b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/sharpen_3x3_rgb_stream.sv */
// top level of the 3x3 rgb sharpening stream: configuration, position counters, input stage
// depends on shp_pkg, shp_line_buf and shp_filter
`timescale 1ns / 1ps

// Takes one RGB pixel per clock in raster order and returns it sharpened with a 3x3
// Laplacian kernel, floor((11*centre - 2*(up+down+left+right))/3) clamped to 0..255,
// always from the original neighbours; pixels of the outer rows and columns pass
// unchanged. A result belongs to the pixel one line plus one pixel earlier, so after
// the last pixel of a frame frame_width+1 results are still owed: send items with
// drain set to push them out, one per item, the last flagged by frame_end. The block
// takes one item every clock while out_stall is low; a result passes the line buffer read,
// the window shift and the result register before it leaves. Writing frame_width or
// frame_height (clamped to 3..1024 and 3..4096) restarts the frame; the user must write
// only while idle (not enforced by the block). Line buffers need no clearing after reset.

module sharpen_3x3_rgb_stream (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  shp_pkg::pixel_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output shp_pkg::pixel_out_t           out_data,
  input  logic                          cfg_wen,
  input  logic [shp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import shp_pkg::*;

  logic [WIDTH_REG_W-1:0]  w_r;
  logic [HEIGHT_REG_W-1:0] h_r;
  logic [COL_W-1:0]        col_r;
  logic [ROW_W-1:0]        row_r;
  logic [WIDTH_REG_W-1:0]  pending_r;

  stage_ctl_t              s1_ctl_r;
  stage_ctl_t              s1_ctl_nxt;
  rgb_t                    s1_px_r;
  logic [COL_W-1:0]        s1_col_r;

  logic                    adv;
  logic                    accept;
  logic                    is_drain;
  logic                    col_last;
  logic                    row_last;
  logic [WIDTH_REG_W-1:0]  drain_k;
  logic [COL_W-1:0]        rd_addr;
  line_word_t              rd_data;
  line_word_t              wr_data;
  logic [WIDTH_REG_W-1:0]  w_val;
  logic [HEIGHT_REG_W-1:0] h_val;

  // whole pipeline moves together; the result register frees when its transfer is done
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign is_drain = in_data.drain;

  assign col_last = ({1'b0, col_r} + 11'd1) >= w_r;
  assign row_last = ({1'b0, row_r} + 13'd1) >= h_r;
  assign drain_k  = w_r + 11'd1 - pending_r;
  assign rd_addr  = is_drain ? drain_k[COL_W-1:0] : col_r;

  // clamp register values once at write time
  always_comb begin
    w_val = cfg_wdata[WIDTH_REG_W-1:0];
    if (w_val < WIDTH_REG_W'(MIN_SIZE)) begin
      w_val = WIDTH_REG_W'(MIN_SIZE);
    end else if (w_val > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_val = WIDTH_REG_W'(MAX_WIDTH);
    end
    h_val = cfg_wdata[HEIGHT_REG_W-1:0];
    if (h_val < HEIGHT_REG_W'(MIN_SIZE)) begin
      h_val = HEIGHT_REG_W'(MIN_SIZE);
    end else if (h_val > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_val = HEIGHT_REG_W'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WIDTH_RESET;
      h_r <= HEIGHT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  w_r <= w_val;
        REG_FRAME_HEIGHT: h_r <= h_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      pending_r <= '0;
    end else if (cfg_wen) begin
      col_r     <= '0;
      row_r     <= '0;
      pending_r <= '0;
    end else if (accept) begin
      if (!is_drain) begin
        pending_r <= '0;
        if (col_last) begin
          col_r <= '0;
          if (row_last) begin
            row_r     <= '0;
            pending_r <= w_r + 11'd1;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
      end else if (pending_r != '0) begin
        pending_r <= pending_r - 1'b1;
      end
    end
  end

  always_comb begin
    s1_ctl_nxt = '0;
    if (in_valid && !is_drain) begin
      s1_ctl_nxt.valid = 1'b1;
      s1_ctl_nxt.pixel = 1'b1;
      s1_ctl_nxt.emit  = (row_r >= 12'd2) || (row_r == 12'd1 && col_r != '0);
      // interior only when the output pixel has all four neighbours
      s1_ctl_nxt.pass  = !(row_r >= 12'd2 && col_r >= 10'd2);
    end else if (in_valid && pending_r != '0) begin
      s1_ctl_nxt.valid     = 1'b1;
      s1_ctl_nxt.zero_col  = drain_k >= w_r;
      s1_ctl_nxt.emit      = 1'b1;
      s1_ctl_nxt.pass      = 1'b1;
      s1_ctl_nxt.frame_end = pending_r == 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r  <= '{r: in_data.red_in, g: in_data.green_in, b: in_data.blue_in};
      s1_col_r <= col_r;
    end
  end

  // the column shifts down one line: old current becomes above
  assign wr_data = '{above: rd_data.current, current: s1_px_r};

  shp_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (adv && s1_ctl_r.valid && s1_ctl_r.pixel),
    .wr_addr (s1_col_r),
    .wr_data (wr_data)
  );

  shp_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1_ctl    (s1_ctl_r),
    .s1_px     (s1_px_r),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < w_r)
    else $error("column counter beyond frame width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_r} < h_r)
    else $error("row counter beyond frame height");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= w_r + 11'd1)
    else $error("more results pending than a line plus one");

  a_last_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_drain && pending_r == 11'd1 |=> s1_ctl_r.valid && s1_ctl_r.frame_end)
    else $error("last drain transfer did not mark frame end");
`endif

endmodule
